[hdl/c8su_pkg.sv]
// ----------------------------------------------------------------------------
// c8su_pkg
// Shared types, command codes, defaults and the hex font for the chip8 state unit.
// ----------------------------------------------------------------------------
package c8su_pkg;

    localparam int MEM_BYTES_DEF   = 4096;
    localparam int REG_COUNT_DEF   = 16;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int FONT_BYTES      = 80;

    localparam logic [15:0] PC_RESET = 16'h0200;

    // command codes
    localparam logic [3:0] CMD_MEM_RD  = 4'd0;
    localparam logic [3:0] CMD_MEM_WR  = 4'd1;
    localparam logic [3:0] CMD_REG_RD  = 4'd2;
    localparam logic [3:0] CMD_REG_UPD = 4'd3;
    localparam logic [3:0] CMD_RET     = 4'd4;
    localparam logic [3:0] CMD_JUMP    = 4'd5;
    localparam logic [3:0] CMD_CALL    = 4'd6;
    localparam logic [3:0] CMD_PC_INC  = 4'd7;
    localparam logic [3:0] CMD_PC_DEC  = 4'd8;
    localparam logic [3:0] CMD_INDEX   = 4'd9;

    // alu operations
    localparam logic [2:0] OP_SET = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_OR  = 3'd3;
    localparam logic [2:0] OP_AND = 3'd4;
    localparam logic [2:0] OP_XOR = 3'd5;
    localparam logic [2:0] OP_SHR = 3'd6;
    localparam logic [2:0] OP_SHL = 3'd7;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [15:0] target_address;
        logic [15:0] jump_offset;
        logic [3:0]  reg_select;
        logic [15:0] data_value;
        logic [2:0]  alu_op;
    } t_cmd_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] pc_value;
        logic [15:0] index_value;
        logic        stack_error;
    } t_result;

    // state updates worked out for one command
    typedef struct packed {
        logic [7:0]  reg_byte;
        logic        reg_we;
        logic [15:0] pc;
        logic [15:0] index;
        logic        push;
        logic        pop;
        logic        err;
    } t_upd;

    localparam logic [7:0] FONT_ROM [0:FONT_BYTES-1] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

endpackage

[hdl/c8su_ram.sv]
// ----------------------------------------------------------------------------
// c8su_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module c8su_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hdl/c8su_alu.sv]
// ----------------------------------------------------------------------------
// c8su_alu
// Works out the register, pc, index and stack updates of one command.
// ----------------------------------------------------------------------------
module c8su_alu #(
    parameter int REG_COUNT   = c8su_pkg::REG_COUNT_DEF,
    parameter int STACK_DEPTH = c8su_pkg::STACK_DEPTH_DEF,
    localparam int LW         = $clog2(STACK_DEPTH + 1)
) (
    input  c8su_pkg::t_cmd_item i_item,
    input  logic [7:0]          i_reg_byte,
    input  logic [15:0]         i_pc,
    input  logic [15:0]         i_index,
    input  logic [LW-1:0]       i_level,
    input  logic [15:0]         i_stack_top,
    output c8su_pkg::t_upd      o_upd
);

    logic [7:0] w_b;
    logic [7:0] w_byte;
    logic       w_big_shift;
    logic       w_reg_ok;
    logic       w_full;
    logic       w_empty;

    assign w_b         = i_item.data_value[7:0];
    assign w_big_shift = (w_b[7:3] != 5'd0);
    assign w_reg_ok    = ({1'b0, i_item.reg_select} < 5'(REG_COUNT));
    assign w_full      = (32'(i_level) >= 32'(STACK_DEPTH));
    assign w_empty     = (i_level == '0);

    always_comb begin
        case (i_item.alu_op)
            c8su_pkg::OP_SET: w_byte = w_b;
            c8su_pkg::OP_ADD: w_byte = i_reg_byte + w_b;
            c8su_pkg::OP_SUB: w_byte = i_reg_byte - w_b;
            c8su_pkg::OP_OR:  w_byte = i_reg_byte | w_b;
            c8su_pkg::OP_AND: w_byte = i_reg_byte & w_b;
            c8su_pkg::OP_XOR: w_byte = i_reg_byte ^ w_b;
            c8su_pkg::OP_SHR: w_byte = w_big_shift ? 8'd0 : (i_reg_byte >> w_b[2:0]);
            c8su_pkg::OP_SHL: w_byte = w_big_shift ? 8'd0 : (i_reg_byte << w_b[2:0]);
            default:          w_byte = w_b;
        endcase
    end

    always_comb begin
        o_upd          = '0;
        o_upd.reg_byte = w_byte;
        o_upd.pc       = i_pc;
        o_upd.index    = i_index;
        case (i_item.cmd)
            c8su_pkg::CMD_REG_UPD: begin
                o_upd.reg_we = w_reg_ok;
            end
            c8su_pkg::CMD_RET: begin
                if (w_empty) begin
                    o_upd.err = 1'b1;
                end else begin
                    o_upd.pop = 1'b1;
                    o_upd.pc  = i_stack_top;
                end
            end
            c8su_pkg::CMD_JUMP: begin
                o_upd.pc = i_item.target_address + i_item.jump_offset - 16'd2;
            end
            c8su_pkg::CMD_CALL: begin
                if (w_full) begin
                    o_upd.err = 1'b1;
                end else begin
                    o_upd.push = 1'b1;
                    o_upd.pc   = i_item.target_address - 16'd2;
                end
            end
            c8su_pkg::CMD_PC_INC: begin
                o_upd.pc = i_pc + 16'd2;
            end
            c8su_pkg::CMD_PC_DEC: begin
                o_upd.pc = i_pc - 16'd2;
            end
            c8su_pkg::CMD_INDEX: begin
                if (i_item.alu_op == c8su_pkg::OP_SET) begin
                    o_upd.index = i_item.data_value;
                end else if (i_item.alu_op == c8su_pkg::OP_ADD) begin
                    o_upd.index = i_index + i_item.data_value;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[hdl/chip8_state_unit.sv]
// ----------------------------------------------------------------------------
// chip8_state_unit
// CHIP-8 machine state: byte memory, registers, return stack, pc and index.
// ----------------------------------------------------------------------------
// result strobe registered out of S_EXEC, reached from accept via S_ADDR only when
// MEM_BYTES is not a power of two; no new item before the last one's memory read and
// read-modify-write are done; busy stays high from accept until the write-back cycle
// reset: a fill pass over all MEM_BYTES addresses loads the font, clears byte memory;
// busy is high meanwhile; results cannot be stalled by the receiver
module chip8_state_unit #(
    parameter int MEM_BYTES   = c8su_pkg::MEM_BYTES_DEF,
    parameter int REG_COUNT   = c8su_pkg::REG_COUNT_DEF,
    parameter int STACK_DEPTH = c8su_pkg::STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  c8su_pkg::t_cmd_item i_item,
    output logic                busy,
    output logic                o_valid,
    output c8su_pkg::t_result   o_result
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int RW = $clog2(REG_COUNT);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam bit MEM_POW2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) + 64'(MEM_BYTES) - 64'd1) /
                                    33'(MEM_BYTES);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_ADDR, S_EXEC} t_state;

    t_state              r_state;
    c8su_pkg::t_cmd_item r_item;
    logic [AW-1:0]       r_clr_addr;
    logic [AW-1:0]       r_mem_addr;
    logic [15:0]         r_quot;
    logic [15:0]         r_pc;
    logic [15:0]         r_index;
    logic [LW-1:0]       r_level;
    logic [REG_COUNT-1:0] r_reg_vld;
    logic                r_valid;
    c8su_pkg::t_result   r_result;

    logic                w_accept;
    c8su_pkg::t_cmd_item w_rd_item;
    logic [48:0]         w_prod;
    logic [31:0]         w_rem;
    logic [31:0]         w_rem_fix;
    logic [AW-1:0]       w_rem_addr;

    logic                w_mem_we;
    logic [AW-1:0]       w_mem_waddr;
    logic [7:0]          w_mem_wdata;
    logic [AW-1:0]       w_mem_raddr;
    logic [7:0]          w_mem_rdata;
    logic [7:0]          w_reg_rdata;
    logic [15:0]         w_stk_rdata;
    logic [LW-1:0]       w_level_dn;
    logic                w_reg_ok;
    logic                w_reg_vld;
    logic [7:0]          w_reg_byte;
    logic [7:0]          w_read_data;
    logic                w_exec;
    c8su_pkg::t_upd      w_upd;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_exec   = (r_state == S_EXEC);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // address reduction for memory sizes that are not a power of two
    assign w_prod     = 49'(i_item.target_address) * 49'(RECIP);
    assign w_rem      = 32'(r_item.target_address) - 32'(r_quot) * 32'(MEM_BYTES);
    assign w_rem_fix  = (w_rem >= 32'(MEM_BYTES)) ? (w_rem - 32'(MEM_BYTES)) : w_rem;
    assign w_rem_addr = w_rem_fix[AW-1:0];

    // read addresses go out in the cycle before the execute cycle
    assign w_rd_item   = (r_state == S_ADDR) ? r_item : i_item;
    assign w_mem_raddr = (r_state == S_ADDR) ? w_rem_addr : i_item.target_address[AW-1:0];
    assign w_level_dn  = r_level - LW'(1);

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_mem_addr;
        w_mem_wdata = r_item.data_value[7:0];
        if (r_state == S_CLEAR) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_addr;
            w_mem_wdata = (32'(r_clr_addr) < 32'(c8su_pkg::FONT_BYTES)) ?
                          c8su_pkg::FONT_ROM[r_clr_addr[6:0]] : 8'd0;
        end else if (w_exec && r_item.cmd == c8su_pkg::CMD_MEM_WR) begin
            w_mem_we = 1'b1;
        end
    end

    c8su_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    c8su_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_regs (
        .i_clk   (i_clk),
        .i_we    (w_exec && w_upd.reg_we),
        .i_waddr (r_item.reg_select[RW-1:0]),
        .i_wdata (w_upd.reg_byte),
        .i_raddr (w_rd_item.reg_select[RW-1:0]),
        .o_rdata (w_reg_rdata)
    );

    c8su_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_exec && w_upd.push),
        .i_waddr (r_level[SW-1:0]),
        .i_wdata (r_pc),
        .i_raddr (w_level_dn[SW-1:0]),
        .o_rdata (w_stk_rdata)
    );

    assign w_reg_ok   = ({1'b0, r_item.reg_select} < 5'(REG_COUNT));
    assign w_reg_vld  = w_reg_ok && r_reg_vld[r_item.reg_select[RW-1:0]];
    // a register never written still reads as zero
    assign w_reg_byte = w_reg_vld ? w_reg_rdata : 8'd0;

    c8su_alu #(.REG_COUNT(REG_COUNT), .STACK_DEPTH(STACK_DEPTH)) u_alu (
        .i_item      (r_item),
        .i_reg_byte  (w_reg_byte),
        .i_pc        (r_pc),
        .i_index     (r_index),
        .i_level     (r_level),
        .i_stack_top (w_stk_rdata),
        .o_upd       (w_upd)
    );

    always_comb begin
        case (r_item.cmd)
            c8su_pkg::CMD_MEM_RD: w_read_data = w_mem_rdata;
            c8su_pkg::CMD_REG_RD: w_read_data = w_reg_byte;
            default:              w_read_data = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_pc       <= c8su_pkg::PC_RESET;
            r_index    <= '0;
            r_level    <= '0;
            r_reg_vld  <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(MEM_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_item     <= i_item;
                        r_mem_addr <= i_item.target_address[AW-1:0];
                        r_quot     <= w_prod[47:32];
                        r_state    <= MEM_POW2 ? S_EXEC : S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_mem_addr <= w_rem_addr;
                    r_state    <= S_EXEC;
                end
                S_EXEC: begin
                    r_pc    <= w_upd.pc;
                    r_index <= w_upd.index;
                    if (w_upd.push) begin
                        r_level <= r_level + LW'(1);
                    end else if (w_upd.pop) begin
                        r_level <= w_level_dn;
                    end
                    if (w_upd.reg_we) begin
                        r_reg_vld[r_item.reg_select[RW-1:0]] <= 1'b1;
                    end
                    r_valid              <= 1'b1;
                    r_result.read_data   <= w_read_data;
                    r_result.pc_value    <= w_upd.pc;
                    r_result.index_value <= w_upd.index;
                    r_result.stack_error <= w_upd.err;
                    r_state              <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/sv/chip8_state_unit_checker.sv]
// ----------------------------------------------------------------------------
// chip8_state_unit_checker
// Watches the command and result channels of the chip8 state unit, keeps its
// own copy of memory, registers, return stack, pc and index, and compares
// every result strobe with the oldest predicted result.
// ----------------------------------------------------------------------------
module chip8_state_unit_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  c8su_pkg::t_cmd_item i_item,
    input  logic                i_valid,
    input  c8su_pkg::t_result   i_result,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_faults
);
    timeunit 1ns;
    timeprecision 1ps;

    import c8su_pkg::*;

    localparam int REPORT_MAX = 40;

    logic [7:0]  mem_image [0:MEM_BYTES_DEF-1];
    logic [7:0]  reg_file  [0:REG_COUNT_DEF-1];
    logic [15:0] ret_stack [0:STACK_DEPTH_DEF-1];
    int          ret_depth;
    logic [15:0] pc_now;
    logic [15:0] index_now;

    t_result     expected_q [$];
    logic [3:0]  cmd_q      [$];

    int err_count     = 0;
    int pending_count = 0;
    int result_count  = 0;
    int fault_count   = 0;

    assign o_errors  = err_count;
    assign o_pending = pending_count;
    assign o_checked = result_count;
    assign o_faults  = fault_count;

    task automatic report_mismatch(input string what);
        if (err_count < REPORT_MAX) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        err_count++;
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want, input logic [3:0] code);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d (cmd %0d) %s: got %h, expected %h",
                                      result_count, code, field, got, want));
        end
    endtask

    function automatic logic [7:0] byte_alu(input logic [7:0] lhs, input logic [7:0] rhs,
                                            input logic [2:0] op);
        case (op)
            OP_SET:  return rhs;
            OP_ADD:  return lhs + rhs;
            OP_SUB:  return lhs - rhs;
            OP_OR:   return lhs | rhs;
            OP_AND:  return lhs & rhs;
            OP_XOR:  return lhs ^ rhs;
            OP_SHR:  return (rhs >= 8'd8) ? 8'h00 : lhs >> rhs;
            default: return (rhs >= 8'd8) ? 8'h00 : lhs << rhs;
        endcase
    endfunction

    // applies one command to the machine copy and returns the result it answers with
    task automatic exec_cmd(input t_cmd_item it, output t_result res);
        int addr;
        addr = int'(it.target_address) % MEM_BYTES_DEF;
        res  = '0;
        case (it.cmd)
            CMD_MEM_RD: res.read_data = mem_image[addr];
            CMD_MEM_WR: mem_image[addr] = it.data_value[7:0];
            CMD_REG_RD: begin
                if (int'(it.reg_select) < REG_COUNT_DEF) begin
                    res.read_data = reg_file[it.reg_select];
                end
            end
            CMD_REG_UPD: begin
                if (int'(it.reg_select) < REG_COUNT_DEF) begin
                    reg_file[it.reg_select] = byte_alu(reg_file[it.reg_select],
                                                       it.data_value[7:0], it.alu_op);
                end
            end
            CMD_RET: begin
                if (ret_depth == 0) begin
                    res.stack_error = 1'b1;
                end else begin
                    ret_depth--;
                    pc_now = ret_stack[ret_depth];
                end
            end
            CMD_JUMP: pc_now = it.target_address + it.jump_offset - 16'd2;
            CMD_CALL: begin
                if (ret_depth >= STACK_DEPTH_DEF) begin
                    res.stack_error = 1'b1;
                end else begin
                    ret_stack[ret_depth] = pc_now;
                    ret_depth++;
                    pc_now = it.target_address - 16'd2;
                end
            end
            CMD_PC_INC: pc_now = pc_now + 16'd2;
            CMD_PC_DEC: pc_now = pc_now - 16'd2;
            CMD_INDEX: begin
                // only set and add touch the index
                if (it.alu_op == OP_SET) begin
                    index_now = it.data_value;
                end else if (it.alu_op == OP_ADD) begin
                    index_now = index_now + it.data_value;
                end
            end
            default: ;
        endcase
        res.pc_value    = pc_now;
        res.index_value = index_now;
    endtask

    always @(posedge i_clk) begin
        t_result    predicted;
        t_result    want;
        logic [3:0] want_cmd;
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_BYTES_DEF; i++) mem_image[i] = 8'h00;
            for (int i = 0; i < FONT_BYTES; i++) mem_image[i] = FONT_ROM[i];
            for (int i = 0; i < REG_COUNT_DEF; i++) reg_file[i] = 8'h00;
            for (int i = 0; i < STACK_DEPTH_DEF; i++) ret_stack[i] = 16'h0000;
            ret_depth = 0;
            pc_now    = PC_RESET;
            index_now = 16'h0000;
            expected_q.delete();
            cmd_q.delete();
        end else begin
            if (i_start && !i_busy) begin
                exec_cmd(i_item, predicted);
                expected_q.push_back(predicted);
                cmd_q.push_back(i_item.cmd);
                if (predicted.stack_error) fault_count++;
            end
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result strobe with no command outstanding");
                end else begin
                    want     = expected_q.pop_front();
                    want_cmd = cmd_q.pop_front();
                    result_count++;
                    check_field("read_data", 16'(i_result.read_data), 16'(want.read_data),
                                want_cmd);
                    check_field("pc_value", i_result.pc_value, want.pc_value, want_cmd);
                    check_field("index_value", i_result.index_value, want.index_value,
                                want_cmd);
                    check_field("stack_error", 16'(i_result.stack_error),
                                16'(want.stack_error), want_cmd);
                end
            end
        end
        pending_count <= expected_q.size();
    end

endmodule

[tb/sv/chip8_state_unit_test.sv]
// ----------------------------------------------------------------------------
// chip8_state_unit_test
// Drives the chip8 state unit with a directed set of corner commands and then
// random commands and call/return bursts, with the sender idling at several
// rates; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module chip8_state_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import c8su_pkg::*;

    localparam int         HALF_PERIOD  = 1;
    localparam int         RESET_CYCLES = 12;
    localparam int         PHASE_ITEMS  = 430;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam logic [3:0] CMD_CODE_MAX = 4'hF;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_cmd_item i_item  = '0;
    logic      busy;
    logic      o_valid;
    t_result   o_result;

    int err_total;
    int pending;
    int checked;
    int faults;
    int cycle_count = 0;
    int idle_pct    = 0;
    int sent        = 0;
    int bursts      = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    chip8_state_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    chip8_state_unit_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_item    (i_item),
        .i_valid   (o_valid),
        .i_result  (o_result),
        .o_errors  (err_total),
        .o_pending (pending),
        .o_checked (checked),
        .o_faults  (faults)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // holds start until the item is taken; returns at the accepting edge
    task automatic send_cmd(input t_cmd_item cmd_item);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= cmd_item;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    function automatic t_cmd_item make_cmd(input logic [3:0] code, input logic [15:0] addr,
                                           input logic [15:0] offset, input logic [3:0] sel,
                                           input logic [15:0] value, input logic [2:0] op);
        t_cmd_item it;
        it.cmd            = code;
        it.target_address = addr;
        it.jump_offset    = offset;
        it.reg_select     = sel;
        it.data_value     = value;
        it.alu_op         = op;
        return it;
    endfunction

    function automatic t_cmd_item random_cmd();
        t_cmd_item it;
        it.target_address = 16'($urandom_range(16'hFFFF));
        it.jump_offset    = 16'($urandom_range(16'hFFFF));
        it.reg_select     = 4'($urandom_range(4'hF));
        it.data_value     = 16'($urandom_range(16'hFFFF));
        it.alu_op         = 3'($urandom_range(OP_SHL, OP_SET));
        if ($urandom_range(24) == 0) begin
            it.cmd = 4'($urandom_range(CMD_CODE_MAX, CMD_INDEX + 4'd1));
        end else begin
            it.cmd = 4'($urandom_range(CMD_INDEX, CMD_MEM_RD));
        end
        // keep most memory traffic in two windows so reads find earlier writes
        case ($urandom_range(3))
            0, 1: it.target_address[11:0] = 12'($urandom_range(127));
            2:    it.target_address[11:0] = 12'hF80 + 12'($urandom_range(127));
            default: ;
        endcase
        if ((it.alu_op == OP_SHR || it.alu_op == OP_SHL) && $urandom_range(1) != 0) begin
            it.data_value[7:0] = 8'($urandom_range(9));
        end
        return it;
    endfunction

    // runs the stack to full (or near it), then returns at least as many times as it called
    task automatic stack_burst();
        int        depth;
        t_cmd_item it;
        depth = $urandom_range(STACK_DEPTH_DEF + 4, STACK_DEPTH_DEF - 2);
        repeat (depth) begin
            it     = random_cmd();
            it.cmd = CMD_CALL;
            send_cmd(it);
        end
        repeat (depth + $urandom_range(2)) begin
            it     = random_cmd();
            it.cmd = CMD_RET;
            send_cmd(it);
        end
        bursts++;
    endtask

    task automatic random_phase(input int pct, input int count);
        int stop;
        idle_pct = pct;
        stop     = sent + count;
        while (sent < stop) begin
            if ($urandom_range(49) == 0) begin
                stack_burst();
            end else begin
                send_cmd(random_cmd());
            end
        end
    endtask

    task automatic directed_cmds();
        idle_pct = 25;
        // font edges, memory wrap and byte truncation
        send_cmd(make_cmd(CMD_MEM_RD, 16'h0000, 16'h0000, 4'h0, 16'h0000, OP_SET));
        send_cmd(make_cmd(CMD_MEM_RD, 16'h004F, 16'h0000, 4'h0, 16'h0000, OP_SET));
        send_cmd(make_cmd(CMD_MEM_RD, 16'h0050, 16'h0000, 4'h0, 16'h0000, OP_SET));
        send_cmd(make_cmd(CMD_MEM_WR, 16'hFFFF, 16'h0000, 4'h0, 16'hFFAB, OP_SET));
        send_cmd(make_cmd(CMD_MEM_RD, 16'h0FFF, 16'h0000, 4'h0, 16'h0000, OP_SET));
        // register alu, wrap both ways and large shifts
        send_cmd(make_cmd(CMD_REG_UPD, 16'h0000, 16'h0000, 4'hF, 16'hFFFF, OP_SET));
        send_cmd(make_cmd(CMD_REG_UPD, 16'h0000, 16'h0000, 4'hF, 16'h0001, OP_ADD));
        send_cmd(make_cmd(CMD_REG_UPD, 16'h0000, 16'h0000, 4'hF, 16'h0001, OP_SUB));
        send_cmd(make_cmd(CMD_REG_UPD, 16'h0000, 16'h0000, 4'hF, 16'h0001, OP_SHR));
        send_cmd(make_cmd(CMD_REG_UPD, 16'h0000, 16'h0000, 4'hF, 16'h0007, OP_SHL));
        send_cmd(make_cmd(CMD_REG_UPD, 16'h0000, 16'h0000, 4'hF, 16'h0081, OP_OR));
        send_cmd(make_cmd(CMD_REG_UPD, 16'h0000, 16'h0000, 4'hF, 16'h000F, OP_AND));
        send_cmd(make_cmd(CMD_REG_UPD, 16'h0000, 16'h0000, 4'hF, 16'h00FF, OP_XOR));
        send_cmd(make_cmd(CMD_REG_RD, 16'h0000, 16'h0000, 4'hF, 16'h0000, OP_SET));
        send_cmd(make_cmd(CMD_REG_UPD, 16'h0000, 16'h0000, 4'hF, 16'h0008, OP_SHR));
        send_cmd(make_cmd(CMD_REG_UPD, 16'h0000, 16'h0000, 4'h0, 16'h00FF, OP_SHL));
        send_cmd(make_cmd(CMD_REG_RD, 16'h0000, 16'h0000, 4'hF, 16'h0000, OP_SET));
        // return on empty stack, call to zero, pc wrap, jump wrap
        send_cmd(make_cmd(CMD_RET, 16'h0000, 16'h0000, 4'h0, 16'h0000, OP_SET));
        send_cmd(make_cmd(CMD_CALL, 16'h0000, 16'h0000, 4'h0, 16'h0000, OP_SET));
        send_cmd(make_cmd(CMD_PC_INC, 16'h0000, 16'h0000, 4'h0, 16'h0000, OP_SET));
        send_cmd(make_cmd(CMD_PC_DEC, 16'h0000, 16'h0000, 4'h0, 16'h0000, OP_SET));
        send_cmd(make_cmd(CMD_RET, 16'h0000, 16'h0000, 4'h0, 16'h0000, OP_SET));
        send_cmd(make_cmd(CMD_JUMP, 16'hFFFF, 16'hFFFF, 4'h0, 16'h0000, OP_SET));
        // index set, add with wrap, ignored op, then an unknown command
        send_cmd(make_cmd(CMD_INDEX, 16'h0000, 16'h0000, 4'h0, 16'hFFFF, OP_SET));
        send_cmd(make_cmd(CMD_INDEX, 16'h0000, 16'h0000, 4'h0, 16'h0001, OP_ADD));
        send_cmd(make_cmd(CMD_INDEX, 16'h0000, 16'h0000, 4'h0, 16'h1234, OP_XOR));
        send_cmd(make_cmd(CMD_CODE_MAX, 16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF, OP_SHL));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_cmds();
        random_phase(25, PHASE_ITEMS);
        random_phase(52, PHASE_ITEMS);
        random_phase(0, PHASE_ITEMS);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d commands (%0d call/return bursts) at sender idle rates 25, 52 and 0",
                 sent, bursts);
        $display("compared %0d results, %0d of them with a stack fault expected",
                 checked, faults);
        if (err_total == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[chip8_state_unit.f]
hdl/c8su_pkg.sv
hdl/c8su_ram.sv
hdl/c8su_alu.sv
hdl/chip8_state_unit.sv
tb/sv/chip8_state_unit_checker.sv
tb/sv/chip8_state_unit_test.sv
